// ----- sv/odps_pkg.sv -----
// Shared types, constants and helpers of the odometry pose and stillness unit.
`default_nettype none

package odps_pkg;

    localparam int WINDOW_DEPTH = 20;
    localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);

    // serial multiplier operand widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam logic [MUL_B_W-1:0] SPEED_GAIN = MUL_B_W'(200);

    localparam logic signed [32:0] WIN_LIMIT   = 33'sd320;
    localparam logic signed [31:0] TURN_LIMIT  = 32'sd2560;
    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd128;
    localparam logic [3:0]         COUNT_MAX   = 4'd15;
    localparam logic [3:0]         COUNT_STILL = 4'd10;

    // register indexes
    localparam logic [2:0] REG_CORRECT_X  = 3'd0;
    localparam logic [2:0] REG_CORRECT_Y  = 3'd1;
    localparam logic [2:0] REG_COUNT_SCL  = 3'd2;
    localparam logic [2:0] REG_ROT_COS    = 3'd3;
    localparam logic [2:0] REG_ROT_SIN    = 3'd4;
    localparam logic [2:0] REG_OFFSET_X   = 3'd5;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd6;
    localparam logic [2:0] REG_HEAD_OFF   = 3'd7;

    typedef struct packed {
        logic signed [31:0] raw_x;
        logic signed [31:0] raw_y;
        logic signed [31:0] raw_heading;
        logic               chassis_ready;
        logic               slide_ready;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_heading;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_heading;
        logic               still;
        logic               angle_still;
    } result_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MUL_P_W:0]  product;
    } mul_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic same;
        same = (&v[66:31]) || !(|v[66:31]);
        if (same)
            return v[31:0];
        else if (v[66])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

`default_nettype wire

// ----- sv/odometry_pose_and_stillness_unit.sv -----
// Top level: pose, speed and stillness of one odometry word per sample.
`default_nettype none

// One sample runs nine products (two count scalings, four rotation terms,
// three speed gains) one after another through a single bit-serial multiplier,
// each through a start state and a wait for the multiplier's done flag; the pose
// is formed between the rotation terms and the speed gains, and a last step
// loads the output register. The next word is accepted the cycle after the
// result has moved to the output register, so a new word is only taken once
// the previous one is through; a held output register stalls the last step and
// the input. The 20-entry window of past positions reads as zero until
// written; no clearing pass is needed after reset. Configuration writes are
// taken at any time but must only be issued while the unit is idle.
module odometry_pose_and_stillness_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire odps_pkg::sample_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output odps_pkg::result_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MWAIT  = 3'd2;
    localparam logic [2:0] S_POSE   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    localparam logic [3:0] OP_SX  = 4'd0;
    localparam logic [3:0] OP_SY  = 4'd1;
    localparam logic [3:0] OP_XC  = 4'd2;
    localparam logic [3:0] OP_YS  = 4'd3;
    localparam logic [3:0] OP_XS  = 4'd4;
    localparam logic [3:0] OP_YC  = 4'd5;
    localparam logic [3:0] OP_VX  = 4'd6;
    localparam logic [3:0] OP_VY  = 4'd7;
    localparam logic [3:0] OP_VH  = 4'd8;

    // configuration
    logic signed [31:0] correct_x_reg, correct_y_reg;
    logic [31:0]        count_scale_reg;
    logic signed [15:0] rot_cos_reg, rot_sin_reg;
    logic signed [31:0] offset_x_reg, offset_y_reg, heading_offset_reg;

    // sequencing
    logic [2:0] state_reg;
    logic [3:0] op_reg;

    // working values
    odps_pkg::sample_t  smp_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [66:0] acc_x_reg, acc_y_reg;
    logic signed [31:0] x_reg, y_reg, h_reg;
    logic signed [31:0] vx_reg, vy_reg, vh_reg;

    // history
    logic signed [31:0] prev_x_reg, prev_y_reg, prev_h_reg;
    logic signed [31:0] win_x_reg [odps_pkg::WINDOW_DEPTH];
    logic signed [31:0] win_y_reg [odps_pkg::WINDOW_DEPTH];
    logic [odps_pkg::WINDOW_DEPTH-1:0] win_vld_reg;
    logic [odps_pkg::WIN_IDX_W-1:0]    win_idx_reg;
    logic [3:0]                        still_cnt_reg, still_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    odps_pkg::result_t    out_reg;

    odps_pkg::mul_req_t   mreq;
    odps_pkg::mul_rsp_t   mrsp;

    logic signed [32:0] dx_cnt, dy_cnt;
    logic signed [32:0] dvx, dvy, dvh;
    logic signed [16:0] cos_w, sin_w;
    logic [32:0]        cos_mag, sin_mag;
    logic [43:0]        q_scl;
    logic               q_big;
    logic signed [31:0] p_scl;
    logic               scl_neg;
    logic signed [31:0] vprod;
    logic signed [31:0] old_x, old_y;
    logic signed [32:0] wx, wy;
    logic               ready_both, still, calm;
    logic               fin_go;

    odps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        dx_cnt  = {smp_reg.raw_x[31], smp_reg.raw_x} - {correct_x_reg[31], correct_x_reg};
        dy_cnt  = {smp_reg.raw_y[31], smp_reg.raw_y} - {correct_y_reg[31], correct_y_reg};
        dvx     = {x_reg[31], x_reg} - {prev_x_reg[31], prev_x_reg};
        dvy     = {y_reg[31], y_reg} - {prev_y_reg[31], prev_y_reg};
        dvh     = {h_reg[31], h_reg} - {prev_h_reg[31], prev_h_reg};
        cos_w   = {rot_cos_reg[15], rot_cos_reg};
        sin_w   = {rot_sin_reg[15], rot_sin_reg};
        cos_mag = odps_pkg::abs33({{16{cos_w[16]}}, cos_w});
        sin_mag = odps_pkg::abs33({{16{sin_w[16]}}, sin_w});

        mreq.start = (state_reg == S_MSTART);
        mreq.neg   = 1'b0;
        mreq.a     = '0;
        mreq.b     = '0;
        unique case (op_reg)
            OP_SX:
            begin
                mreq.a = odps_pkg::abs33(dx_cnt);
                mreq.b = count_scale_reg;
            end
            OP_SY:
            begin
                mreq.a = odps_pkg::abs33(dy_cnt);
                mreq.b = count_scale_reg;
            end
            OP_XC:
            begin
                mreq.a   = odps_pkg::abs33({px_reg[31], px_reg});
                mreq.b   = cos_mag[31:0];
                mreq.neg = px_reg[31] ^ rot_cos_reg[15];
            end
            OP_YS:
            begin
                mreq.a   = odps_pkg::abs33({py_reg[31], py_reg});
                mreq.b   = sin_mag[31:0];
                mreq.neg = py_reg[31] ^ rot_sin_reg[15];
            end
            OP_XS:
            begin
                mreq.a   = odps_pkg::abs33({px_reg[31], px_reg});
                mreq.b   = sin_mag[31:0];
                mreq.neg = px_reg[31] ^ rot_sin_reg[15];
            end
            OP_YC:
            begin
                mreq.a   = odps_pkg::abs33({py_reg[31], py_reg});
                mreq.b   = cos_mag[31:0];
                mreq.neg = py_reg[31] ^ rot_cos_reg[15];
            end
            OP_VX:
            begin
                mreq.a   = odps_pkg::abs33(dvx);
                mreq.b   = odps_pkg::SPEED_GAIN;
                mreq.neg = dvx[32];
            end
            OP_VY:
            begin
                mreq.a   = odps_pkg::abs33(dvy);
                mreq.b   = odps_pkg::SPEED_GAIN;
                mreq.neg = dvy[32];
            end
            OP_VH:
            begin
                mreq.a   = odps_pkg::abs33(dvh);
                mreq.b   = odps_pkg::SPEED_GAIN;
                mreq.neg = dvh[32];
            end
            default:
            begin
                mreq.a = '0;
            end
        endcase

        // counts to mm: drop 20 bits, clamp magnitudes of 2^31 and more to the 32-bit signed limits, restore the sign
        q_scl   = mrsp.product[63:20];
        q_big   = |q_scl[43:31];
        scl_neg = (op_reg == OP_SX) ? dx_cnt[32] : dy_cnt[32];
        if (scl_neg)
            p_scl = q_big ? 32'sh8000_0000 : -$signed(q_scl[31:0]);
        else
            p_scl = q_big ? 32'sh7FFF_FFFF : $signed(q_scl[31:0]);

        vprod = odps_pkg::sat32(67'(mrsp.product));

        old_x = win_vld_reg[win_idx_reg] ? win_x_reg[win_idx_reg] : 32'sd0;
        old_y = win_vld_reg[win_idx_reg] ? win_y_reg[win_idx_reg] : 32'sd0;
        wx    = {x_reg[31], x_reg} - {old_x[31], old_x};
        wy    = {y_reg[31], y_reg} - {old_y[31], old_y};

        ready_both = smp_reg.chassis_ready & smp_reg.slide_ready;
        still = (wx < odps_pkg::WIN_LIMIT) && (wx > -odps_pkg::WIN_LIMIT)
             && (wy < odps_pkg::WIN_LIMIT) && (wy > -odps_pkg::WIN_LIMIT)
             && (vh_reg < odps_pkg::TURN_LIMIT) && (vh_reg > -odps_pkg::TURN_LIMIT)
             && ready_both;
        calm = (vx_reg == 32'sd0) && (vy_reg == 32'sd0)
            && (vh_reg < odps_pkg::ANGLE_LIMIT) && (vh_reg > -odps_pkg::ANGLE_LIMIT);

        if (still && calm)
            still_cnt_next = (still_cnt_reg < odps_pkg::COUNT_MAX)
                           ? still_cnt_reg + 4'd1 : still_cnt_reg;
        else
            still_cnt_next = '0;

        fin_go = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

        // drop the word once taken, raise it when a new one is loaded
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (fin_go)
            out_valid_next = 1'b1;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            correct_x_reg      <= '0;
            correct_y_reg      <= '0;
            count_scale_reg    <= 32'd16777216;
            rot_cos_reg        <= 16'sd16384;
            rot_sin_reg        <= '0;
            offset_x_reg       <= '0;
            offset_y_reg       <= '0;
            heading_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                odps_pkg::REG_CORRECT_X: correct_x_reg      <= cfg_data;
                odps_pkg::REG_CORRECT_Y: correct_y_reg      <= cfg_data;
                odps_pkg::REG_COUNT_SCL: count_scale_reg    <= cfg_data;
                odps_pkg::REG_ROT_COS:   rot_cos_reg        <= cfg_data[15:0];
                odps_pkg::REG_ROT_SIN:   rot_sin_reg        <= cfg_data[15:0];
                odps_pkg::REG_OFFSET_X:  offset_x_reg       <= cfg_data;
                odps_pkg::REG_OFFSET_Y:  offset_y_reg       <= cfg_data;
                odps_pkg::REG_HEAD_OFF:  heading_offset_reg <= cfg_data;
                default:                 correct_x_reg      <= correct_x_reg;
            endcase
        end
    end

    // sequencer and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_SX;
            out_valid_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_h_reg    <= '0;
            win_vld_reg   <= '0;
            win_idx_reg   <= '0;
            still_cnt_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= OP_SX;
                        state_reg <= S_MSTART;
                    end
                end
                S_MSTART:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mrsp.done)
                    begin
                        op_reg <= op_reg + 4'd1;
                        if (op_reg == OP_YC)
                            state_reg <= S_POSE;
                        else if (op_reg == OP_VH)
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_MSTART;
                    end
                end
                S_POSE:
                begin
                    state_reg <= S_MSTART;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        prev_x_reg    <= x_reg;
                        prev_y_reg    <= y_reg;
                        prev_h_reg    <= h_reg;
                        win_vld_reg[win_idx_reg] <= 1'b1;
                        win_idx_reg   <= (win_idx_reg ==
                                          odps_pkg::WIN_IDX_W'(odps_pkg::WINDOW_DEPTH - 1))
                                       ? '0 : win_idx_reg + 1'b1;
                        still_cnt_reg <= still_cnt_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            smp_reg <= in_data;

        if (state_reg == S_MWAIT && mrsp.done)
        begin
            case (op_reg)
                OP_SX: px_reg    <= p_scl;
                OP_SY: py_reg    <= p_scl;
                OP_XC: acc_x_reg <= 67'(mrsp.product);
                OP_YS: acc_x_reg <= acc_x_reg - 67'(mrsp.product);
                OP_XS: acc_y_reg <= 67'(mrsp.product);
                OP_YC: acc_y_reg <= acc_y_reg + 67'(mrsp.product);
                OP_VX: vx_reg    <= vprod;
                OP_VY: vy_reg    <= vprod;
                OP_VH: vh_reg    <= vprod;
                default: vh_reg  <= vh_reg;
            endcase
        end

        if (state_reg == S_POSE)
        begin
            // floor shift by 14, then add the offset
            x_reg <= odps_pkg::sat32((acc_x_reg >>> 14) + 67'(offset_x_reg));
            y_reg <= odps_pkg::sat32((acc_y_reg >>> 14) + 67'(offset_y_reg));
            h_reg <= odps_pkg::sat32(67'(smp_reg.raw_heading) + 67'(heading_offset_reg));
        end

        if (fin_go)
        begin
            win_x_reg[win_idx_reg] <= x_reg;
            win_y_reg[win_idx_reg] <= y_reg;
            out_reg.pos_x         <= x_reg;
            out_reg.pos_y         <= y_reg;
            out_reg.pos_heading   <= h_reg;
            out_reg.speed_x       <= vx_reg;
            out_reg.speed_y       <= vy_reg;
            out_reg.speed_heading <= vh_reg;
            out_reg.still         <= still;
            out_reg.angle_still   <= (still_cnt_next > odps_pkg::COUNT_STILL);
        end
    end

endmodule

`default_nettype wire

// ----- sv/odps_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, sign applied at the end.
`default_nettype none

module odps_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire odps_pkg::mul_req_t req,
    output odps_pkg::mul_rsp_t      rsp
);

    logic [odps_pkg::MUL_P_W-1:0]   p_reg, p_next;
    logic [odps_pkg::MUL_A_W-1:0]   a_reg;
    logic                           neg_reg;
    logic [odps_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [odps_pkg::MUL_A_W:0]     sum;

    always_comb
    begin
        sum = {1'b0, p_reg[odps_pkg::MUL_P_W-1:odps_pkg::MUL_B_W]}
            + (p_reg[0] ? {1'b0, a_reg} : '0);
        p_next = {sum, p_reg[odps_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == odps_pkg::MUL_CNT_W'(odps_pkg::MUL_B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            p_reg   <= {{odps_pkg::MUL_A_W{1'b0}}, req.b};
            a_reg   <= req.a;
            neg_reg <= req.neg;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    always_comb
    begin
        rsp.done    = done_reg;
        rsp.product = neg_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
    end

endmodule

`default_nettype wire

// ----- tb/odometry_pose_and_stillness_unit_tb.sv -----
// Testbench for the odometry pose and stillness unit: directed and random samples, self-checking.
`timescale 1ns / 1ps

module odometry_pose_and_stillness_unit_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    odps_pkg::sample_t   in_data;
    logic                out_valid;
    logic                out_ready;
    odps_pkg::result_t   out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    odometry_pose_and_stillness_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] reg_file [8];
    longint      last_x, last_y, last_h;
    longint      ring_x [odps_pkg::WINDOW_DEPTH];
    longint      ring_y [odps_pkg::WINDOW_DEPTH];
    int          ring_pos;
    int          calm_count;

    odps_pkg::result_t pending_results[$];
    int          errors;
    int          hold_off;
    bit          random_stalls;

    always #5 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor14(input longint v);
        return v >>> 14;
    endfunction

    function automatic longint counts_to_mm(input longint d, input logic [31:0] scl);
        logic [63:0] m;
        logic [63:0] q;
        m = (d < 0) ? 64'(-d) : 64'(d);
        q = ((m * scl[31:16]) + ((m * scl[15:0]) >> 16)) >> 4;
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return clamp32((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic predictor_reset();
        reg_file[odps_pkg::REG_CORRECT_X] = '0;
        reg_file[odps_pkg::REG_CORRECT_Y] = '0;
        reg_file[odps_pkg::REG_COUNT_SCL] = 32'd16777216;
        reg_file[odps_pkg::REG_ROT_COS]   = 32'd16384;
        reg_file[odps_pkg::REG_ROT_SIN]   = '0;
        reg_file[odps_pkg::REG_OFFSET_X]  = '0;
        reg_file[odps_pkg::REG_OFFSET_Y]  = '0;
        reg_file[odps_pkg::REG_HEAD_OFF]  = '0;
        last_x = 0; last_y = 0; last_h = 0;
        for (int i = 0; i < odps_pkg::WINDOW_DEPTH; i++)
        begin
            ring_x[i] = 0;
            ring_y[i] = 0;
        end
        ring_pos = 0;
        calm_count = 0;
    endtask

    function automatic odps_pkg::result_t predict_pose(input odps_pkg::sample_t s);
        odps_pkg::result_t r;
        longint  px, py, c, sn, x, y, h, vx, vy, vh, wx, wy;
        bit      still;
        px = counts_to_mm(longint'(s.raw_x)
                          - longint'($signed(reg_file[odps_pkg::REG_CORRECT_X])),
                          reg_file[odps_pkg::REG_COUNT_SCL]);
        py = counts_to_mm(longint'(s.raw_y)
                          - longint'($signed(reg_file[odps_pkg::REG_CORRECT_Y])),
                          reg_file[odps_pkg::REG_COUNT_SCL]);
        c  = longint'($signed(reg_file[odps_pkg::REG_ROT_COS][15:0]));
        sn = longint'($signed(reg_file[odps_pkg::REG_ROT_SIN][15:0]));
        x  = clamp32(floor14(px * c - py * sn)
                     + longint'($signed(reg_file[odps_pkg::REG_OFFSET_X])));
        y  = clamp32(floor14(px * sn + py * c)
                     + longint'($signed(reg_file[odps_pkg::REG_OFFSET_Y])));
        h  = clamp32(longint'(s.raw_heading)
                     + longint'($signed(reg_file[odps_pkg::REG_HEAD_OFF])));
        vx = clamp32((x - last_x) * 200);
        vy = clamp32((y - last_y) * 200);
        vh = clamp32((h - last_h) * 200);
        // read the oldest position before overwriting it
        wx = x - ring_x[ring_pos];
        wy = y - ring_y[ring_pos];
        ring_x[ring_pos] = x;
        ring_y[ring_pos] = y;
        ring_pos = (ring_pos + 1) % odps_pkg::WINDOW_DEPTH;
        last_x = x; last_y = y; last_h = h;
        still = mag(wx) < 320 && mag(wy) < 320 && mag(vh) < 2560
                && s.chassis_ready && s.slide_ready;
        if (still && vx == 0 && vy == 0 && mag(vh) < 128)
        begin
            if (calm_count < 15)
                calm_count++;
        end
        else
            calm_count = 0;
        r.pos_x = x[31:0];
        r.pos_y = y[31:0];
        r.pos_heading = h[31:0];
        r.speed_x = vx[31:0];
        r.speed_y = vy[31:0];
        r.speed_heading = vh[31:0];
        r.still = still;
        r.angle_still = calm_count > 10;
        return r;
    endfunction

    task automatic send_sample(input odps_pkg::sample_t s);
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_pose(s));
        @(negedge clk);
        // random gap between bursts
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(negedge clk);
        end
    endtask

    task automatic finish_sending();
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_file[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        finish_sending();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    function automatic odps_pkg::sample_t rand_sample();
        odps_pkg::sample_t s;
        s.raw_x = $urandom;
        s.raw_y = $urandom;
        s.raw_heading = $urandom;
        s.chassis_ready = 1'($urandom_range(0, 1));
        s.slide_ready = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic logic [31:0] rand_trig();
        return 32'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, out_data);
                errors++;
            end
            else
            begin
                odps_pkg::result_t e;
                e = pending_results.pop_front();
                if (e !== out_data)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (random_stalls)
            out_ready <= ($urandom_range(0, 9) > 2);
        else
            out_ready <= 1'b1;
    end

    task automatic test_directed();
        odps_pkg::sample_t s;
        // extremes of every field
        s = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1};
        send_sample(s);
        s = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1};
        send_sample(s);
        s = '{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0};
        send_sample(s);
        s = '{32'shFFFF_FFFF, 32'sh1, 32'sh0, 1'b0, 1'b0};
        send_sample(s);
        // hold still long enough for the angle flag, then nudge the heading
        for (int i = 0; i < 14; i++)
        begin
            s = '{32'sd5, 32'sd5, 32'sd10, 1'b1, 1'b1};
            send_sample(s);
        end
        s = '{32'sd5, 32'sd5, 32'sd11, 1'b1, 1'b1};
        send_sample(s);
        s = '{32'sd5, 32'sd5, 32'sd30, 1'b1, 1'b1};
        send_sample(s);
        drain();
    endtask

    task automatic test_config_extremes();
        odps_pkg::sample_t s;
        write_reg(odps_pkg::REG_CORRECT_X, 32'h8000_0000);
        write_reg(odps_pkg::REG_CORRECT_Y, 32'h7FFF_FFFF);
        write_reg(odps_pkg::REG_COUNT_SCL, 32'hFFFF_FFFF);
        write_reg(odps_pkg::REG_ROT_COS, 32'(-16384));
        write_reg(odps_pkg::REG_ROT_SIN, 32'd16384);
        write_reg(odps_pkg::REG_OFFSET_X, 32'h7FFF_FFFF);
        write_reg(odps_pkg::REG_OFFSET_Y, 32'h8000_0000);
        write_reg(odps_pkg::REG_HEAD_OFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
        begin
            s = rand_sample();
            if (i == 0)
                s.raw_x = 32'sh7FFF_FFFF;
            send_sample(s);
        end
        drain();
        write_reg(odps_pkg::REG_COUNT_SCL, 32'h0);
        write_reg(odps_pkg::REG_HEAD_OFF, 32'h8000_0000);
        for (int i = 0; i < 3; i++)
            send_sample(rand_sample());
        drain();
    endtask

    task automatic test_random_phase(input int n, input bit near_home);
        odps_pkg::sample_t s;
        logic signed [31:0] bx, by, bh;
        bx = $urandom;
        by = $urandom;
        bh = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if (near_home && $urandom_range(0, 9) != 0)
            begin
                // small wander around a point so stillness and the angle flag occur
                if ($urandom_range(0, 5) == 0)
                begin
                    bx = bx + $signed($urandom_range(0, 8)) - 4;
                    by = by + $signed($urandom_range(0, 8)) - 4;
                    bh = bh + $signed($urandom_range(0, 20)) - 10;
                end
                s.raw_x = bx;
                s.raw_y = by;
                s.raw_heading = bh;
                s.chassis_ready = ($urandom_range(0, 9) != 0);
                s.slide_ready = ($urandom_range(0, 9) != 0);
            end
            else
                s = rand_sample();
            send_sample(s);
        end
        drain();
    endtask

    task automatic test_random_config();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(odps_pkg::REG_CORRECT_X,
                      (p % 2) ? $urandom : 32'($urandom_range(0, 2000)));
            write_reg(odps_pkg::REG_CORRECT_Y,
                      (p % 2) ? $urandom : 32'($urandom_range(0, 2000)));
            write_reg(odps_pkg::REG_COUNT_SCL,
                      (p % 2) ? $urandom : 32'($urandom_range(1, 1 << 25)));
            write_reg(odps_pkg::REG_ROT_COS, rand_trig());
            write_reg(odps_pkg::REG_ROT_SIN, rand_trig());
            write_reg(odps_pkg::REG_OFFSET_X,
                      (p % 2) ? $urandom : 32'($urandom_range(0, 5000)));
            write_reg(odps_pkg::REG_OFFSET_Y,
                      (p % 2) ? $urandom : 32'($urandom_range(0, 5000)));
            write_reg(odps_pkg::REG_HEAD_OFF, $urandom);
            random_stalls = (p != 2);
            test_random_phase(100, (p % 2) == 0);
        end
    endtask

    task automatic test_backpressure();
        write_reg(odps_pkg::REG_COUNT_SCL, 32'd16777216);
        write_reg(odps_pkg::REG_ROT_COS, 32'd16384);
        write_reg(odps_pkg::REG_ROT_SIN, 32'd0);
        @(negedge clk);
        hold_off = 2000;
        test_random_phase(10, 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        hold_off = 0;
        random_stalls = 1'b1;
        predictor_reset();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_random_config();
        test_backpressure();

        repeat (400)
            @(negedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
